// ===== rtl/lfdt_pkg.sv =====
`default_nettype none

package lfdt_pkg;

  localparam int MAX_FDS     = 32;
  localparam int HANDLE_BITS = 16;
  localparam int IDX_BITS    = (MAX_FDS > 1) ? $clog2(MAX_FDS) : 1;

  localparam int OPCODE_W = 2;
  localparam int DESC_W   = 8;
  localparam int FH_W     = 16;
  localparam int STATUS_W = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_MANY  = 3'd1,
    ST_BAD_FD    = 3'd2,
    ST_NOT_READ  = 3'd3,
    ST_NOT_WRITE = 3'd4
  } status_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [DESC_W-1:0] descriptor;
    logic [FH_W-1:0]   file_handle;
    logic              read_bit;
    logic              write_bit;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [DESC_W-1:0] result_descriptor;
    logic [FH_W-1:0]   result_handle;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/lfdt_in_reg.sv =====
`default_nettype none

module lfdt_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire lfdt_pkg::req_t req_in,
  input  wire logic          advance,
  output logic               stall,
  output logic               q_valid,
  output lfdt_pkg::req_t     q
);

  logic accept;

  assign stall  = q_valid && !advance;
  assign accept = in_valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q <= req_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lfdt_table.sv =====
`default_nettype none

module lfdt_table (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          exec,
  input  wire lfdt_pkg::req_t req,
  output lfdt_pkg::res_t     res
);

  logic [lfdt_pkg::MAX_FDS-1:0]     slot_valid;
  logic [lfdt_pkg::HANDLE_BITS-1:0] slot_handle [lfdt_pkg::MAX_FDS];
  logic [1:0]                       slot_mode   [lfdt_pkg::MAX_FDS];

  logic                          free_found;
  logic [lfdt_pkg::IDX_BITS-1:0] free_idx;
  logic                          in_range;
  logic [lfdt_pkg::IDX_BITS-1:0] fd_idx;
  logic                          fd_live;
  logic [1:0]                    fd_mode;
  logic [lfdt_pkg::HANDLE_BITS-1:0] fd_handle;

  // Lowest free slot: scan from the top so the lowest index wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = lfdt_pkg::MAX_FDS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = lfdt_pkg::IDX_BITS'(i);
      end
    end
  end

  assign in_range  = ({1'b0, req.descriptor} < (lfdt_pkg::DESC_W + 1)'(lfdt_pkg::MAX_FDS));
  assign fd_idx    = lfdt_pkg::IDX_BITS'(req.descriptor);
  assign fd_live   = in_range && slot_valid[fd_idx];
  assign fd_mode   = slot_mode[fd_idx];
  assign fd_handle = slot_handle[fd_idx];

  always_comb begin
    res = '{status: lfdt_pkg::ST_OK, result_descriptor: '0, result_handle: '0};
    unique case (req.opcode)
      lfdt_pkg::OP_ALLOC: begin
        if (!free_found) begin
          res.status = lfdt_pkg::ST_TOO_MANY;
        end else begin
          res.result_descriptor = lfdt_pkg::DESC_W'(free_idx);
        end
      end
      lfdt_pkg::OP_FREE: begin
        if (!fd_live) begin
          res.status = lfdt_pkg::ST_BAD_FD;
        end
      end
      lfdt_pkg::OP_LOOKUP: begin
        if (!fd_live) begin
          res.status = lfdt_pkg::ST_BAD_FD;
        end else if (req.read_bit && !fd_mode[0]) begin
          res.status = lfdt_pkg::ST_NOT_READ;
        end else if (req.write_bit && !fd_mode[1]) begin
          res.status = lfdt_pkg::ST_NOT_WRITE;
        end else begin
          res.result_handle = lfdt_pkg::FH_W'(fd_handle);
        end
      end
      lfdt_pkg::OP_CLEAR: begin
        res.status = lfdt_pkg::ST_OK;
      end
      default: begin
        res.status = lfdt_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (exec) begin
      case (req.opcode)
        lfdt_pkg::OP_ALLOC: if (free_found) slot_valid[free_idx] <= 1'b1;
        lfdt_pkg::OP_FREE:  if (fd_live) slot_valid[fd_idx] <= 1'b0;
        lfdt_pkg::OP_CLEAR: slot_valid <= '0;
        default: ;
      endcase
    end
  end

  // Payload only: entries are read only once their valid bit is set.
  always_ff @(posedge clk) begin
    if (exec && req.opcode == lfdt_pkg::OP_ALLOC && free_found) begin
      slot_handle[free_idx] <= lfdt_pkg::HANDLE_BITS'(req.file_handle);
      slot_mode[free_idx]   <= {req.write_bit, req.read_bit};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lfdt_out_reg.sv =====
`default_nettype none

module lfdt_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire lfdt_pkg::res_t res_in,
  input  wire logic          out_stall,
  output logic               ready,
  output logic               out_valid,
  output lfdt_pkg::res_t     q
);

  // Room for a new result when empty or when the held one leaves now.
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= res_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lowest_free_descriptor_table.sv =====
// Lowest-free descriptor table: 32 slots, each holding a 16-bit file handle
// and read/write permission bits. Allocate takes the lowest free slot,
// free releases one, lookup returns the handle after an access check, and
// clear empties the table; every request transaction yields exactly one
// result transaction. One transaction is taken per clock cycle sustained
// while out_stall is low; a request is held in the request register and
// its result then loads into the result register once that register has
// room. The per-request work, a priority encoder over the 32-bit valid
// map plus one slot read, sits between those two registers, and the table
// update lands on the same edge that loads the result, so back-to-back
// requests always see each other's effects. The valid map is cleared by
// reset; no clearing pass is needed.
`default_nettype none

module lowest_free_descriptor_table (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  descriptor,
  input  wire logic [15:0] file_handle,
  input  wire logic        read_bit,
  input  wire logic        write_bit,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [7:0]       result_descriptor,
  output logic [15:0]      result_handle
);

  lfdt_pkg::req_t req_in;
  lfdt_pkg::req_t req_q;
  lfdt_pkg::res_t res_comb;
  lfdt_pkg::res_t res_q;
  logic           req_valid;
  logic           out_ready;
  logic           exec;

  // Gather the request transaction into one struct.
  assign req_in = '{opcode:      lfdt_pkg::opcode_t'(opcode),
                    descriptor:  descriptor,
                    file_handle: file_handle,
                    read_bit:    read_bit,
                    write_bit:   write_bit};

  // Execute the held request whenever the result register has room.
  assign exec = req_valid && out_ready;

  lfdt_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_in   (req_in),
    .advance  (out_ready),
    .stall    (in_stall),
    .q_valid  (req_valid),
    .q        (req_q)
  );

  lfdt_table u_table (
    .clk  (clk),
    .rst  (rst),
    .exec (exec),
    .req  (req_q),
    .res  (res_comb)
  );

  lfdt_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (exec),
    .res_in    (res_comb),
    .out_stall (out_stall),
    .ready     (out_ready),
    .out_valid (out_valid),
    .q         (res_q)
  );

  // Drive the result transaction fields.
  assign status            = res_q.status;
  assign result_descriptor = res_q.result_descriptor;
  assign result_handle     = res_q.result_handle;

endmodule

`default_nettype wire

// ===== rtl/lfdt_checker.sv =====
`default_nettype none

module lfdt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  status,
  input wire logic [7:0]  result_descriptor,
  input wire logic [15:0] result_handle
);

  // Status stays within the defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == lfdt_pkg::ST_OK || status == lfdt_pkg::ST_TOO_MANY ||
                   status == lfdt_pkg::ST_BAD_FD || status == lfdt_pkg::ST_NOT_READ ||
                   status == lfdt_pkg::ST_NOT_WRITE))
    else $error("status code out of range");

  // A failed request carries no descriptor and no handle.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != lfdt_pkg::ST_OK) |-> (result_descriptor == '0 &&
                                                  result_handle == '0))
    else $error("failed request returned payload");

  // Allocate and lookup results never both carry data.
  a_one_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_descriptor == '0 || result_handle == '0))
    else $error("descriptor and handle both nonzero");

  // An allocated slot lies inside the table.
  a_desc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, result_descriptor} < 9'(lfdt_pkg::MAX_FDS)))
    else $error("allocated descriptor beyond capacity");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) &&
                                  $stable(result_descriptor) && $stable(result_handle)))
    else $error("stalled result changed");

endmodule

bind lowest_free_descriptor_table lfdt_checker u_lfdt_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .status            (status),
  .result_descriptor (result_descriptor),
  .result_handle     (result_handle)
);

`default_nettype wire
